### design/adsr_pkg.sv
// Shared constants, types, control structs and sine table builder for the ADSR voice.
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    // Table and time format
    localparam int SINE_TABLE_BITS = 10;
    localparam int TIME_FRAC_BITS  = 24;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;
    localparam int SINE_Q          = SINE_N >> 2;
    localparam int PHASE_SHIFT     = TIME_FRAC_BITS - 8;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // Noise generator
    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'hFFFF;

    // Shared divider: 48-bit dividend, 32-bit divisor, 16-bit quotient
    localparam int DIV_Q_W   = 16;
    localparam int DIV_D_W   = 32;
    localparam int DIV_N_W   = DIV_Q_W + DIV_D_W;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_LEN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY_LEN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN_LEN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_LEN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_WAVE_SELECT   = 3'd5;

    // Wave select codes; anything above noise is silent
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [2:0] WAVE_NOISE    = 3'd3;
    localparam logic [2:0] WAVE_SILENT   = 3'd4;

    // Unity level in Q1.15
    localparam logic [16:0] ENV_ONE = 17'd32768;

    typedef enum logic [1:0] {
        STAGE_ATTACK  = 2'd0,
        STAGE_DECAY   = 2'd1,
        STAGE_SUSTAIN = 2'd2,
        STAGE_RELEASE = 2'd3
    } stage_t;

    typedef enum logic [2:0] {
        ENV_QUOT,
        ENV_DEC_ADD,
        ENV_DEC_SUB,
        ENV_LEVEL,
        ENV_ZERO
    } env_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_CALC3,
        ST_MULT,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_ENV,
        ST_PROD,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic [31:0] attack_len;
        logic [31:0] decay_len;
        logic [31:0] sustain_len;
        logic [31:0] release_len;
        logic [15:0] sustain_level;
        logic [2:0]  wave_select;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic calc1;
        logic calc2;
        logic calc3;
        logic mult;
        logic div_start;
        logic env;
        logic prod;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // Full-cycle sine table, entry k in bits [16k+15:16k], two's complement Q1.15
    typedef logic [SINE_N-1:0][15:0] sine_rom_t;

    // Taylor term divide by (2n)(2n+1)
    function automatic longint unsigned taylor_div(input longint unsigned v, input int n);
        longint unsigned res;
        unique case (n)
            1:       res = v / 6;
            2:       res = v / 20;
            3:       res = v / 42;
            4:       res = v / 72;
            5:       res = v / 110;
            default: res = v / 156;
        endcase
        return res;
    endfunction

    // Quarter wave in Q1.15 from a Q30 series, r in 0..SINE_Q
    function automatic logic [15:0] quarter_sine(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned v;
        int n;
        x    = (r * PI_HALF_Q30) / SINE_Q;
        x2   = (x * x) >> 30;
        sum  = x;
        term = x;
        for (n = 1; n <= 6; n++) begin
            term = taylor_div((term * x2) >> 30, n);
            if ((n & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[15:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        int k;
        int quad;
        int r;
        logic [15:0] v;
        for (k = 0; k < SINE_N; k++) begin
            quad = k / SINE_Q;
            r    = k % SINE_Q;
            if ((quad & 1) != 0) begin
                v = quarter_sine(64'(SINE_Q - r));
            end else begin
                v = quarter_sine(64'(r));
            end
            if ((quad & 2) != 0) begin
                rom[k] = -$signed(v);
            end else begin
                rom[k] = $signed(v);
            end
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

### design/adsr_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the attack, decay and release stages.
`timescale 1ns / 1ps
`default_nettype none

module adsr_divider
    import adsr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] dividend,
    input  wire logic [DIV_D_W-1:0] divisor,
    output logic                    busy,
    output logic [DIV_Q_W-1:0]      quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   dsr_reg;

    logic [DIV_D_W:0] trial;
    logic [DIV_D_W:0] diff;
    logic             ge;

    // Shift next dividend bit in from the top of the quotient register
    assign trial = {rem_reg, quo_reg[DIV_Q_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_Q_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DIV_N_W-1:DIV_Q_W];
            quo_reg <= dividend[DIV_Q_W-1:0];
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### design/adsr_datapath.sv
// Envelope, oscillator and output register datapath for the ADSR voice.
`timescale 1ns / 1ps
`default_nettype none

module adsr_datapath
    import adsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire dp_cmd_t     cmd,
    input  wire logic [31:0] note_time,
    input  wire logic [20:0] tone_freq,
    input  wire logic [31:0] sustain_extension,
    input  wire logic        m_ready,
    output dp_status_t       status,
    output logic             m_valid,
    output logic [15:0]      sample_out,
    output logic [1:0]       envelope_stage
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Item registers
    logic [31:0] t_reg;
    logic [20:0] freq_reg;
    logic [31:0] ext_reg;

    // Stage selection
    logic [32:0] end_d_reg;
    logic [32:0] sus_sum_reg;
    logic [33:0] end_s_reg;
    logic [33:0] end_s_next;
    stage_t      stage_reg;
    stage_t      stage_next;

    // Oscillator phase
    logic [52:0]        phase_prod_reg;
    logic [16:0]        phase;
    logic signed [15:0] sine_reg;

    // Operands for multiply and divide
    logic [15:0] mul_a_reg;
    logic [15:0] mul_a_next;
    logic [31:0] mul_b_reg;
    logic [31:0] mul_b_next;
    logic [31:0] divisor_reg;
    logic [31:0] divisor_next;
    env_mode_t   mode_reg;
    env_mode_t   mode_next;
    logic [47:0] dividend_reg;

    logic [32:0] dec_span;
    logic [16:0] dec_gap;
    logic [31:0] rel_x;
    logic [31:0] rel_rem;

    logic              div_busy;
    logic [DIV_Q_W-1:0] quotient;

    // Envelope and wave
    logic signed [18:0] env_raw;
    logic [16:0]        env_next;
    logic [16:0]        env_reg;
    logic signed [16:0] wave_next;
    logic signed [16:0] wave_reg;
    logic [15:0]        lfsr_reg;
    logic [15:0]        lfsr_next;
    logic signed [17:0] tri_diff;
    logic signed [17:0] tri_abs;
    logic signed [17:0] tri_wave;

    // Product and output
    logic signed [17:0] env_s;
    logic signed [34:0] prod_next;
    logic signed [34:0] prod_reg;
    logic signed [34:0] prod_adj;
    logic signed [34:0] prod_shift;
    logic [15:0]        sample_next;

    logic        m_valid_reg;
    logic [15:0] sample_reg;
    logic [1:0]  stage_out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            t_reg    <= note_time;
            freq_reg <= tone_freq;
            ext_reg  <= sustain_extension;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc1) begin
            end_d_reg      <= {1'b0, cfg.attack_len} + {1'b0, cfg.decay_len};
            sus_sum_reg    <= {1'b0, cfg.sustain_len} + {1'b0, ext_reg};
            phase_prod_reg <= 53'(t_reg) * 53'(freq_reg);
        end
    end

    assign end_s_next = {1'b0, end_d_reg} + {1'b0, sus_sum_reg};
    assign phase      = phase_prod_reg[PHASE_SHIFT+16:PHASE_SHIFT];

    always_comb begin
        priority if (t_reg < cfg.attack_len) begin
            stage_next = STAGE_ATTACK;
        end else if ({1'b0, t_reg} < end_d_reg) begin
            stage_next = STAGE_DECAY;
        end else if ({2'b0, t_reg} < end_s_next) begin
            stage_next = STAGE_SUSTAIN;
        end else begin
            stage_next = STAGE_RELEASE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc2) begin
            end_s_reg <= end_s_next;
            stage_reg <= stage_next;
            sine_reg  <= SINE_ROM[phase[15 -: SINE_TABLE_BITS]];
        end
    end

    assign dec_span = end_d_reg - {1'b0, t_reg};
    assign dec_gap  = ENV_ONE - {1'b0, cfg.sustain_level};
    assign rel_x    = t_reg - end_s_reg[31:0];
    assign rel_rem  = cfg.release_len - rel_x;

    always_comb begin
        mul_a_next   = '0;
        mul_b_next   = '0;
        divisor_next = '0;
        mode_next    = ENV_LEVEL;
        unique case (stage_reg)
            STAGE_ATTACK: begin
                mul_a_next   = ENV_ONE[15:0] ^ 16'h0000;
                mul_b_next   = t_reg;
                divisor_next = cfg.attack_len;
                mode_next    = ENV_QUOT;
            end
            STAGE_DECAY: begin
                // Gap to unity may be negative when the level exceeds one
                if ({1'b0, cfg.sustain_level} > ENV_ONE) begin
                    mul_a_next = cfg.sustain_level - ENV_ONE[15:0];
                    mode_next  = ENV_DEC_SUB;
                end else begin
                    mul_a_next = dec_gap[15:0];
                    mode_next  = ENV_DEC_ADD;
                end
                mul_b_next   = dec_span[31:0];
                divisor_next = cfg.decay_len;
            end
            STAGE_SUSTAIN: begin
                mode_next = ENV_LEVEL;
            end
            STAGE_RELEASE: begin
                // Past the release end the level would be negative: clamp to zero
                if (cfg.release_len == '0 || rel_x >= cfg.release_len) begin
                    mode_next = ENV_ZERO;
                end else begin
                    mul_a_next   = cfg.sustain_level;
                    mul_b_next   = rel_rem;
                    divisor_next = cfg.release_len;
                    mode_next    = ENV_QUOT;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc3) begin
            mul_a_reg   <= mul_a_next;
            mul_b_reg   <= mul_b_next;
            divisor_reg <= divisor_next;
            mode_reg    <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            dividend_reg <= 48'(mul_a_reg) * 48'(mul_b_reg);
        end
    end

    adsr_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb begin
        unique case (mode_reg)
            ENV_QUOT:    env_raw = $signed({3'b0, quotient});
            ENV_DEC_ADD: env_raw = $signed({3'b0, cfg.sustain_level}) +
                                   $signed({3'b0, quotient});
            ENV_DEC_SUB: env_raw = $signed({3'b0, cfg.sustain_level}) -
                                   $signed({3'b0, quotient});
            ENV_LEVEL:   env_raw = $signed({3'b0, cfg.sustain_level});
            default:     env_raw = '0;
        endcase
        if (env_raw < 0) begin
            env_next = '0;
        end else if (env_raw > $signed({2'b0, ENV_ONE})) begin
            env_next = ENV_ONE;
        end else begin
            env_next = env_raw[16:0];
        end
    end

    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
    assign tri_diff  = 18'sd65536 - $signed({1'b0, phase});
    assign tri_abs   = (tri_diff < 0) ? -tri_diff : tri_diff;
    assign tri_wave  = 18'sd32768 - tri_abs;

    always_comb begin
        unique case (cfg.wave_select)
            WAVE_SINE:     wave_next = {sine_reg[15], sine_reg};
            WAVE_SQUARE:   wave_next = phase[15] ? 17'sh08000 : 17'sh18000;
            WAVE_TRIANGLE: wave_next = tri_wave[16:0];
            WAVE_NOISE:    wave_next = $signed({1'b0, lfsr_next} - 17'd32768);
            default:       wave_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.env) begin
            env_reg  <= env_next;
            wave_reg <= wave_next;
        end
    end

    // Advance the noise register only on noise items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= LFSR_SEED;
        end else if (cmd.env && cfg.wave_select == WAVE_NOISE) begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign env_s     = $signed({1'b0, env_reg});
    assign prod_next = env_s * wave_reg;

    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            prod_reg <= prod_next;
        end
    end

    // Divide by 32768 with truncation toward zero, then saturate the top
    assign prod_adj   = prod_reg[34] ? (prod_reg + 35'sd32767) : prod_reg;
    assign prod_shift = prod_adj >>> 15;
    assign sample_next = (prod_shift > 35'sd32767) ? 16'h7FFF : prod_shift[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sample_reg    <= sample_next;
            stage_out_reg <= stage_reg;
        end
    end

    assign status.div_busy = div_busy;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign sample_out      = sample_reg;
    assign envelope_stage  = stage_out_reg;

endmodule

`default_nettype wire

### design/adsr_ctrl.sv
// Sequencer that steps one item through the ADSR voice datapath.
`timescale 1ns / 1ps
`default_nettype none

module adsr_ctrl
    import adsr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire dp_status_t status,
    output logic            in_ready,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_CALC1;
            ST_CALC1:    state_next = ST_CALC2;
            ST_CALC2:    state_next = ST_CALC3;
            ST_CALC3:    state_next = ST_MULT;
            ST_MULT:     state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (!status.div_busy) state_next = ST_ENV;
            ST_ENV:      state_next = ST_PROD;
            ST_PROD:     state_next = ST_OUT;
            ST_OUT:      if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_CALC1:    cmd.calc1     = 1'b1;
            ST_CALC2:    cmd.calc2     = 1'b1;
            ST_CALC3:    cmd.calc3     = 1'b1;
            ST_MULT:     cmd.mult      = 1'b1;
            ST_DIV_LOAD: cmd.div_start = 1'b1;
            ST_DIV_WAIT: cmd           = '0;
            ST_ENV:      cmd.env       = 1'b1;
            ST_PROD:     cmd.prod      = 1'b1;
            ST_OUT:      cmd.out_load  = status.out_free;
            default:     cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

### design/adsr_envelope_oscillator_voice.sv
// Top level of the ADSR envelope voice: ports, configuration registers and assertions.
//
// Usage:
//   The s_ channel takes one item per note sample: note time (Q8.24 s), tone
//   frequency (Q13.8 Hz) and a sustain extension (Q8.24 s). The m_ channel
//   returns one item per input: the Q1.15 sample in tdata and the ADSR stage
//   in tuser. Envelope lengths, sustain level and wave select come in over
//   the cfg_ write port; write them only while no item is in flight.
// Timing:
//   m_tvalid rises in the same cycle that s_tready returns, so the block takes
//   no new item before the last one is through. The time per item is set by
//   the shared 16-step restoring divider (one quotient bit a cycle) plus the
//   setup, multiply, envelope and product registers around it.
// Reset:
//   aresetn low (synchronous) drops any item in flight, empties the output
//   register, restores the register defaults (all zero, wave select silent)
//   and reloads the noise register with all ones.
// Stall:
//   A finished item waits in the output register while m_tready is low; the
//   next item may already be accepted and is held in its final step until
//   the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_oscillator_voice
    import adsr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input item channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] note_time, [52:32] tone_freq, [84:53] sustain_extension, [87:85] zero
    input  wire logic [87:0]           s_tdata,
    // Result item channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [15:0] sample_out
    output logic [15:0]                m_tdata,
    // [1:0] envelope_stage
    output logic [1:0]                 m_tuser
);

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t dp_status;

    // Hold configuration; out-of-range indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_len    <= '0;
            cfg_reg.decay_len     <= '0;
            cfg_reg.sustain_len   <= '0;
            cfg_reg.release_len   <= '0;
            cfg_reg.sustain_level <= '0;
            cfg_reg.wave_select   <= WAVE_SILENT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ATTACK_LEN:    cfg_reg.attack_len    <= cfg_wdata;
                REG_DECAY_LEN:     cfg_reg.decay_len     <= cfg_wdata;
                REG_SUSTAIN_LEN:   cfg_reg.sustain_len   <= cfg_wdata;
                REG_RELEASE_LEN:   cfg_reg.release_len   <= cfg_wdata;
                REG_SUSTAIN_LEVEL: cfg_reg.sustain_level <= cfg_wdata[15:0];
                REG_WAVE_SELECT:   cfg_reg.wave_select   <= cfg_wdata[2:0];
                default:           cfg_reg.wave_select   <= cfg_reg.wave_select;
            endcase
        end
    end

    // Sequence each item through setup, divide, envelope and product steps
    adsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .status   (dp_status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // Unpack the item and compute the sample
    adsr_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .cmd               (cmd),
        .note_time         (s_tdata[31:0]),
        .tone_freq         (s_tdata[52:32]),
        .sustain_extension (s_tdata[84:53]),
        .m_ready           (m_tready),
        .status            (dp_status),
        .m_valid           (m_tvalid),
        .sample_out        (m_tdata),
        .envelope_stage    (m_tuser)
    );

    // The divider never runs while a new item may be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dp_status.div_busy)
        else $error("divider busy while input is ready");

    // A divide start is always followed by a busy divider
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> dp_status.div_busy)
        else $error("divider failed to start");

    // Only one item is in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

    // The output register is loaded only when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while full");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the ADSR envelope oscillator voice.
`timescale 1ns / 1ps

module tb_top;
    import adsr_pkg::*;

    localparam int     HALF_PERIOD   = 6;
    localparam int     RESET_CYCLES  = 3;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     CYCLE_LIMIT   = 1_500_000;
    localparam int     ITEM_TARGET   = 1750;
    localparam int     MAX_REPORTS   = 10;
    localparam longint TIME_MAX      = 64'h0000_0000_FFFF_FFFF;
    localparam int     FREQ_MAX      = 2097151;
    localparam int     HZ            = 256;       // one hertz in Q13.8
    localparam logic [31:0] ONE_SEC  = 32'h0100_0000;

    // Register indexes past the end of the map; writes to them must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
    // Highest wave code; silent like every code above noise
    localparam logic [2:0] WAVE_UNUSED_TOP = 3'd7;

    // Input item, packed so that note_time lands in the low bits of s_tdata
    typedef struct packed {
        logic [31:0] sustain_ext;
        logic [20:0] tone_freq;
        logic [31:0] note_time;
    } voice_item_t;

    typedef struct packed {
        logic [15:0] sample;
        stage_t      stage;
    } voice_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // [31:0] note_time, [52:32] tone_freq, [84:53] sustain_extension, [87:85] zero
    logic [87:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [15:0] sample_out
    logic [15:0]           m_tdata;
    // [1:0] envelope_stage
    logic [1:0]            m_tuser;

    adsr_envelope_oscillator_voice dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Shadow copy of the voice registers and the noise generator
    logic [31:0] len_attack    = '0;
    logic [31:0] len_decay     = '0;
    logic [31:0] len_sustain   = '0;
    logic [31:0] len_release   = '0;
    logic [15:0] level_sustain = '0;
    logic [2:0]  wave_sel      = WAVE_SILENT;
    logic [15:0] noise_state   = LFSR_SEED;
    int          sine_table [SINE_N];

    voice_item_t   pending_items [$];
    voice_result_t expected_samples [$];
    voice_item_t   current_item;
    voice_result_t want;

    int items_queued = 0;
    int results_seen = 0;
    int error_count  = 0;
    int cycle_count  = 0;
    int calm_cycles  = 0;
    int send_gap     = 0;
    int stall_left   = 0;

    // One quarter-wave entry in Q1.15: Taylor series of sin(x) in Q30
    function automatic int quarter_wave(input int r);
        longint unsigned x, x2, acc, term, v;
        int n;
        x    = (longint'(r) * PI_HALF_Q30) / SINE_Q;
        x2   = (x * x) >> 30;
        acc  = x;
        term = x;
        for (n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        v = (acc * 32767 + (64'd1 << 29)) >> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return int'(v);
    endfunction

    // Expected result of one item; steps the noise shadow when noise is selected
    function automatic voice_result_t voice_sample(input voice_item_t it);
        longint          t, a, d, r, lvl, end_d, end_s, env, wave, prod, ph, frac, u;
        longint unsigned tu, fq, raw;
        logic            lsb;
        voice_result_t   res;
        t     = it.note_time;
        a     = len_attack;
        d     = len_decay;
        r     = len_release;
        lvl   = level_sustain;
        end_d = a + d;
        end_s = end_d + longint'(len_sustain) + longint'(it.sustain_ext);

        // Pick the stage from the time; zero attack or decay falls through
        if (t < a) begin
            res.stage = STAGE_ATTACK;
            env       = (t * 32768) / a;
        end else if (t < end_d) begin
            res.stage = STAGE_DECAY;
            env       = lvl + ((32768 - lvl) * (end_d - t)) / d;
        end else if (t < end_s) begin
            res.stage = STAGE_SUSTAIN;
            env       = lvl;
        end else begin
            res.stage = STAGE_RELEASE;
            env       = (r == 0) ? 0 : (lvl * (r - (t - end_s))) / r;
        end
        if (env < 0) env = 0;
        if (env > 32768) env = 32768;

        // Phase is time*freq as Q1.16: one integer bit over a 16-bit fraction
        tu   = it.note_time;
        fq   = it.tone_freq;
        raw  = (tu * fq) >> (TIME_FRAC_BITS - 8);
        ph   = raw & 64'h1FFFF;
        frac = ph & 64'hFFFF;

        case (wave_sel)
            WAVE_SINE: begin
                wave = sine_table[frac >> (16 - SINE_TABLE_BITS)];
            end
            WAVE_SQUARE: begin
                wave = (frac < 32'h8000) ? -32768 : 32768;
            end
            WAVE_TRIANGLE: begin
                u = 65536 - ph;
                if (u < 0) u = -u;
                wave = 32768 - u;
            end
            WAVE_NOISE: begin
                lsb         = noise_state[0];
                noise_state = noise_state >> 1;
                if (lsb) noise_state = noise_state ^ LFSR_MASK;
                wave = {48'd0, noise_state};
                wave = wave - 32768;
            end
            default: begin
                wave = 0;
            end
        endcase

        prod = (env * wave) / 32768;
        if (prod < -32768) prod = -32768;
        if (prod > 32767) prod = 32767;
        res.sample = prod[15:0];
        return res;
    endfunction

    // Idle length: mostly short, sometimes medium, rarely long
    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 16);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [31:0] draw_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom_range(1, 255);
            7:       return $urandom_range(1, 1 << 28);
            8:       return $urandom;
            9:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 1 << 26);
        endcase
    endfunction

    // Level word: upper bits are don't-care for the block, so fill them at times
    function automatic logic [31:0] draw_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd32768;
            2:       return 32'd65535;
            3:       return $urandom;
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    function automatic logic [31:0] draw_wave_word();
        logic [2:0] code;
        case ($urandom_range(0, 9))
            0, 1:    code = WAVE_SINE;
            2, 3:    code = WAVE_SQUARE;
            4, 5:    code = WAVE_TRIANGLE;
            6, 7:    code = WAVE_NOISE;
            8:       code = WAVE_SILENT;
            default: code = WAVE_SILENT + 3'($urandom_range(0, 3));
        endcase
        return {(($urandom_range(0, 3) == 0) ? 29'($urandom) : 29'd0), code};
    endfunction

    // Random note sample aimed at one stage of the current envelope
    function automatic voice_item_t note_item();
        voice_item_t     it;
        longint          a, end_d, end_s, rel_end, lo, hi;
        longint unsigned rnd;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.sustain_ext = '0;
            5, 6, 7:       it.sustain_ext = $urandom_range(1, 1 << 25);
            8:             it.sustain_ext = $urandom;
            default:       it.sustain_ext = 32'hFFFF_FFFF;
        endcase
        case ($urandom_range(0, 9))
            0:       it.tone_freq = '0;
            1:       it.tone_freq = 21'(FREQ_MAX);
            2, 3:    it.tone_freq = 21'($urandom_range(0, FREQ_MAX));
            default: it.tone_freq = 21'($urandom_range(20 * HZ, 4000 * HZ));
        endcase
        a       = len_attack;
        end_d   = a + longint'(len_decay);
        end_s   = end_d + longint'(len_sustain) + longint'(it.sustain_ext);
        rel_end = end_s + longint'(len_release);
        lo      = 0;
        hi      = TIME_MAX;
        case ($urandom_range(0, 9))
            0, 1: begin lo = 0;     hi = a - 1;     end
            2, 3: begin lo = a;     hi = end_d - 1; end
            4, 5: begin lo = end_d; hi = end_s - 1; end
            6, 7: begin
                lo = end_s;
                hi = rel_end + longint'(len_release / 4);
            end
            8: begin
                // Land exactly on a stage boundary or one step before it
                case ($urandom_range(0, 7))
                    0:       lo = a - 1;
                    1:       lo = a;
                    2:       lo = end_d - 1;
                    3:       lo = end_d;
                    4:       lo = end_s - 1;
                    5:       lo = end_s;
                    6:       lo = rel_end - 1;
                    default: lo = rel_end;
                endcase
                hi = lo;
            end
            default: ;
        endcase
        if (lo < 0) lo = 0;
        if (hi > TIME_MAX) hi = TIME_MAX;
        // Stage out of reach of 32-bit time: take any time at all
        if (lo > hi) begin
            lo = 0;
            hi = TIME_MAX;
        end
        rnd          = {$urandom, $urandom};
        it.note_time = 32'(lo + longint'(rnd % longint'(hi - lo + 1)));
        return it;
    endfunction

    task automatic queue_item(input logic [31:0] t, input logic [20:0] f,
                              input logic [31:0] e);
        voice_item_t it;
        it.note_time   = t;
        it.tone_freq   = f;
        it.sustain_ext = e;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Drive one register write onto the port and mirror the write into the shadow copy
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_ATTACK_LEN:    len_attack    = value;
            REG_DECAY_LEN:     len_decay     = value;
            REG_SUSTAIN_LEN:   len_sustain   = value;
            REG_RELEASE_LEN:   len_release   = value;
            REG_SUSTAIN_LEVEL: level_sustain = value[15:0];
            REG_WAVE_SELECT:   wave_sel      = value[2:0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_voice(input logic [31:0] a, input logic [31:0] d,
                                 input logic [31:0] s, input logic [31:0] r,
                                 input logic [31:0] lvl, input logic [31:0] wave);
        write_reg(REG_ATTACK_LEN, a);
        write_reg(REG_DECAY_LEN, d);
        write_reg(REG_SUSTAIN_LEN, s);
        write_reg(REG_RELEASE_LEN, r);
        write_reg(REG_SUSTAIN_LEVEL, lvl);
        write_reg(REG_WAVE_SELECT, wave);
    endtask

    // Wait until every queued item has come back, then let the pipeline drain
    task automatic settle();
        while (results_seen < items_queued) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Stimulus sequencer: directed phases first, then randomized voices
    initial begin
        int k, quad, rem, v, n, i, random_items;
        for (k = 0; k < SINE_N; k++) begin
            quad = k / SINE_Q;
            rem  = k % SINE_Q;
            v    = (quad % 2 == 1) ? quarter_wave(SINE_Q - rem) : quarter_wave(rem);
            sine_table[k] = (quad >= 2) ? -v : v;
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: all lengths zero, wave silent
        queue_item('0, '0, '0);
        queue_item(32'hFFFF_FFFF, 21'(FREQ_MAX), 32'hFFFF_FFFF);
        queue_item(32'd5, 21'(1000 * HZ), '0);
        settle();

        // Sine through attack, sustain and release, including the clamp past the release end
        program_voice(ONE_SEC, ONE_SEC / 2, ONE_SEC, ONE_SEC, 32'h4000, WAVE_SINE);
        close_writes();
        queue_item(32'h0000_0000, 21'(440 * HZ), ONE_SEC / 16);
        queue_item(32'h0080_0000, 21'(1000 * HZ + 128), ONE_SEC / 16);
        queue_item(32'h01C0_0000, 21'(FREQ_MAX), ONE_SEC / 16);
        queue_item(32'h0200_0000, '0, ONE_SEC / 16);
        queue_item(32'h028F_FFFF, 21'd12345, ONE_SEC / 16);
        queue_item(32'h0290_0000, 21'(3000 * HZ), ONE_SEC / 16);
        queue_item(32'h0310_0000, 21'(777 * HZ), ONE_SEC / 16);
        queue_item(32'h04A0_0000, 21'(50 * HZ), ONE_SEC / 16);
        queue_item(32'hFFFF_FFFF, 21'(FREQ_MAX), 32'hFFFF_FFFF);
        settle();

        // Square, zero attack/decay/release, level above one; spare indexes ignored
        program_voice('0, '0, ONE_SEC, '0, 32'hFFFF_FFFF, WAVE_SQUARE);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        close_writes();
        queue_item('0, 21'(100 * HZ), '0);
        queue_item(ONE_SEC + 5, 21'(200 * HZ), '0);
        queue_item(ONE_SEC - 1, 21'(8000 * HZ + 128), '0);
        settle();

        // Triangle with the longest attack, decay and release lengths, zero sustain and unity level
        program_voice(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 32'd32768,
                      WAVE_TRIANGLE);
        close_writes();
        queue_item(32'hFFFF_FFFE, 21'(FREQ_MAX), '0);
        queue_item(32'h1234_5678, 21'(440 * HZ), '0);
        queue_item('0, '0, '0);
        settle();

        // Noise, then a silent code, then noise again: the LFSR holds while silent
        program_voice(ONE_SEC / 4, ONE_SEC / 4, ONE_SEC / 4, ONE_SEC / 4, 32'h6000,
                      WAVE_NOISE);
        close_writes();
        queue_item(32'h0020_0000, 21'(440 * HZ), '0);
        queue_item(32'h0060_0000, 21'(440 * HZ), '0);
        queue_item(32'h00A0_0000, 21'(440 * HZ), '0);
        settle();
        write_reg(REG_WAVE_SELECT, WAVE_UNUSED_TOP);
        close_writes();
        queue_item(32'h0020_0000, 21'(880 * HZ), '0);
        queue_item(32'h0120_0000, 21'(880 * HZ), '0);
        settle();
        write_reg(REG_WAVE_SELECT, WAVE_NOISE);
        close_writes();
        queue_item(32'h0040_0000, 21'(220 * HZ), '0);
        queue_item(32'h0140_0000, 21'(220 * HZ), '0);
        settle();

        // Random voices: fresh registers per phase, notes aimed at each stage
        random_items = 0;
        while (random_items < ITEM_TARGET) begin
            program_voice(draw_length(), draw_length(), draw_length(), draw_length(),
                          draw_level(), draw_wave_word());
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            end
            close_writes();
            n = $urandom_range(30, 150);
            for (i = 0; i < n; i++) begin
                pending_items.push_back(note_item());
                items_queued++;
            end
            random_items += n;
            settle();
        end

        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Driver: present queued items, predict each one as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_samples.push_back(voice_sample(current_item));
            end
            // Advance only when the slot is empty or its item was just taken
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    current_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, current_item};
                    send_gap = (calm_cycles == 0 && $urandom_range(0, 99) < 40)
                               ? draw_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_samples.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("unexpected result %0d: sample %0d stage %0d",
                                 results_seen, $signed(m_tdata), m_tuser);
                    end
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata !== want.sample || m_tuser !== want.stage) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("result %0d: sample exp %0d got %0d, stage exp %0d got %0d",
                                     results_seen, $signed(want.sample), $signed(m_tdata),
                                     want.stage, m_tuser);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (calm_cycles == 0 && $urandom_range(0, 99) < 20) begin
                    stall_left = draw_gap();
                end
            end
        end
    end

    // Watchdog, plus occasional stretches where neither side idles
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (calm_cycles > 0) begin
            calm_cycles <= calm_cycles - 1;
        end else if ($urandom_range(0, 1999) == 0) begin
            calm_cycles <= $urandom_range(100, 600);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
